/* rtl/core/segi_pkg.sv */
// ----------------------------------------------------------------------------
// segi_pkg
// Shared widths, codes and types of the 2D segment intersection pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;

  // fixed point format of all coordinates
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int TOL_W     = 16;

  // exact widths of the cross products
  localparam int VEC_W  = COORD_W + 1;           // start difference
  localparam int DPRD_W = 2 * COORD_W;           // direction by direction
  localparam int VPRD_W = VEC_W + COORD_W;       // difference by direction
  localparam int DEN_W  = DPRD_W + 1;
  localparam int NUM_W  = VPRD_W + 1;

  // quotient bits: enough to hold one plus the largest tolerance
  localparam int MAXF  = (FRAC_BITS > TOL_W) ? FRAC_BITS : TOL_W;
  localparam int QW    = MAXF + 2;
  localparam int TW    = QW + 1;                 // signed parameter
  localparam int DIV_W = (NUM_W - 1) + FRAC_BITS + QW;

  // pipeline depths
  localparam int FRONT_LAT = 3;
  localparam int DIV_LAT   = QW + 2;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT;

  typedef enum logic [1:0] {
    OC_HIT      = 2'd0,
    OC_PARALLEL = 2'd1,
    OC_OUTSIDE  = 2'd2
  } outcome_t;

  // data carried beside the dividers
  typedef struct packed {
    logic signed [COORD_W-1:0] sax;
    logic signed [COORD_W-1:0] say;
    logic signed [COORD_W-1:0] dax;
    logic signed [COORD_W-1:0] day;
    logic                      den_zero;
  } seg_side_t;

endpackage

/* rtl/core/segi_front.sv */
// ----------------------------------------------------------------------------
// segi_front
// Three stage front end: start difference, six products, cross products.
// ----------------------------------------------------------------------------
module segi_front import segi_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COORD_W-1:0] sax,
  input  logic signed [COORD_W-1:0] say,
  input  logic signed [COORD_W-1:0] dax,
  input  logic signed [COORD_W-1:0] day,
  input  logic signed [COORD_W-1:0] sbx,
  input  logic signed [COORD_W-1:0] sby,
  input  logic signed [COORD_W-1:0] dbx,
  input  logic signed [COORD_W-1:0] dby,
  output logic signed [DEN_W-1:0]   den,
  output logic signed [NUM_W-1:0]   num1,
  output logic signed [NUM_W-1:0]   num2,
  output seg_side_t                 side
);

  // stage 1 registers
  logic signed [VEC_W-1:0]   vx_r, vy_r;
  logic signed [COORD_W-1:0] dax1_r, day1_r, dbx1_r, dby1_r, sax1_r, say1_r;
  // stage 2 registers
  logic signed [DPRD_W-1:0]  pd0_r, pd1_r;
  logic signed [VPRD_W-1:0]  pv0_r, pv1_r, pv2_r, pv3_r;
  logic signed [COORD_W-1:0] dax2_r, day2_r, sax2_r, say2_r;
  // stage 3 registers
  logic signed [DEN_W-1:0]   den_r;
  logic signed [NUM_W-1:0]   num1_r, num2_r;
  seg_side_t                 side_r;

  // start point difference
  always_ff @(posedge clk) begin
    if (en) begin
      vx_r   <= VEC_W'(sbx) - VEC_W'(sax);
      vy_r   <= VEC_W'(sby) - VEC_W'(say);
      dax1_r <= dax;
      day1_r <= day;
      dbx1_r <= dbx;
      dby1_r <= dby;
      sax1_r <= sax;
      say1_r <= say;
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      pd0_r  <= DPRD_W'(dax1_r) * DPRD_W'(dby1_r);
      pd1_r  <= DPRD_W'(day1_r) * DPRD_W'(dbx1_r);
      pv0_r  <= VPRD_W'(vx_r) * VPRD_W'(dby1_r);
      pv1_r  <= VPRD_W'(vy_r) * VPRD_W'(dbx1_r);
      pv2_r  <= VPRD_W'(vx_r) * VPRD_W'(day1_r);
      pv3_r  <= VPRD_W'(vy_r) * VPRD_W'(dax1_r);
      dax2_r <= dax1_r;
      day2_r <= day1_r;
      sax2_r <= sax1_r;
      say2_r <= say1_r;
    end
  end

  // cross products
  always_ff @(posedge clk) begin
    if (en) begin
      den_r           <= DEN_W'(pd0_r) - DEN_W'(pd1_r);
      num1_r          <= NUM_W'(pv0_r) - NUM_W'(pv1_r);
      num2_r          <= NUM_W'(pv2_r) - NUM_W'(pv3_r);
      side_r.sax      <= sax2_r;
      side_r.say      <= say2_r;
      side_r.dax      <= dax2_r;
      side_r.day      <= day2_r;
      side_r.den_zero <= (pd0_r == pd1_r);
    end
  end

  assign den  = den_r;
  assign num1 = num1_r;
  assign num2 = num2_r;
  assign side = side_r;

endmodule

/* rtl/core/segi_div.sv */
// ----------------------------------------------------------------------------
// segi_div
// Pipelined restoring divider: (|num| << FRAC_BITS) / |den|, one quotient
// bit per stage, with a flag for quotients that do not fit in QW bits.
// ----------------------------------------------------------------------------
module segi_div import segi_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic [QW-1:0]           quo,
  output logic                    neg,
  output logic                    ovf
);

  logic [NUM_W-1:0] nmag;
  logic [DEN_W-1:0] dmag;
  logic [DIV_W-1:0] n_a_r, d_a_r;
  logic             neg_a_r;

  logic [DIV_W-1:0] rem_r [QW+1];
  logic [DIV_W-1:0] d_r   [QW+1];
  logic [QW-1:0]    q_r   [QW+1];
  logic             neg_r [QW+1];
  logic             ovf_r [QW+1];

  // magnitudes and result sign
  always_comb begin
    nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dmag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_a_r   <= DIV_W'(nmag) << FRAC_BITS;
      d_a_r   <= DIV_W'(dmag);
      neg_a_r <= num[NUM_W-1] ^ den[DEN_W-1];
    end
  end

  // range check: quotient of more than QW bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n_a_r;
      d_r[0]   <= d_a_r;
      q_r[0]   <= '0;
      neg_r[0] <= neg_a_r;
      ovf_r[0] <= (n_a_r >= (d_a_r << QW));
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_bit
    logic [DIV_W-1:0] dsh;
    logic             ge;

    always_comb begin
      dsh = d_r[k] << (QW - 1 - k);
      ge  = (rem_r[k] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? (rem_r[k] - dsh) : rem_r[k];
        d_r[k+1]   <= d_r[k];
        q_r[k+1]   <= {q_r[k][QW-2:0], ge};
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quo = q_r[QW];
  assign neg = neg_r[QW];
  assign ovf = ovf_r[QW];

endmodule

/* rtl/core/segi_point.sv */
// ----------------------------------------------------------------------------
// segi_point
// Parameter range check, outcome code, intersection point with saturation,
// and the result register.
// ----------------------------------------------------------------------------
module segi_point import segi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [QW-1:0]             q1,
  input  logic                      neg1,
  input  logic                      ovf1,
  input  logic [QW-1:0]             q2,
  input  logic                      neg2,
  input  logic                      ovf2,
  input  seg_side_t                 side,
  input  logic [TOL_W-1:0]          tol,
  output logic                      out_vld,
  output logic                      hit,
  output logic [1:0]                outcome,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y
);

  localparam int RW    = TW + 1;
  localparam int PRD_W = COORD_W + TW;
  localparam int SUM_W = PRD_W + 1;
  localparam int ONE   = 1 << FRAC_BITS;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    $signed({{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO =
    $signed({{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});

  logic signed [RW-1:0] t1_w, t2_w, lo_w, hi_w;
  logic                 ok1, ok2;
  outcome_t             oc_nxt;

  // stage p1
  logic                      v1_r;
  logic signed [TW-1:0]      t1_r;
  outcome_t                  oc1_r;
  logic signed [COORD_W-1:0] sax1_r, say1_r, dax1_r, day1_r;
  // stage p2
  logic                      v2_r;
  logic signed [PRD_W-1:0]   prx_r, pry_r;
  outcome_t                  oc2_r;
  logic signed [COORD_W-1:0] sax2_r, say2_r;
  // result register
  logic                      out_vld_r;
  outcome_t                  oc_r;
  logic signed [COORD_W-1:0] px_r, py_r;

  logic signed [SUM_W-1:0]   sumx, sumy;

  // signed parameters and tolerance window
  always_comb begin
    lo_w   = -$signed(RW'(tol));
    hi_w   = $signed(RW'(ONE)) + $signed(RW'(tol));
    t1_w   = neg1 ? -$signed(RW'(q1)) : $signed(RW'(q1));
    t2_w   = neg2 ? -$signed(RW'(q2)) : $signed(RW'(q2));
    ok1    = !ovf1 && (t1_w >= lo_w) && (t1_w <= hi_w);
    ok2    = !ovf2 && (t2_w >= lo_w) && (t2_w <= hi_w);
    if (side.den_zero) begin
      oc_nxt = OC_PARALLEL;
    end else if (ok1 && ok2) begin
      oc_nxt = OC_HIT;
    end else begin
      oc_nxt = OC_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= TW'(t1_w);
      oc1_r  <= oc_nxt;
      sax1_r <= side.sax;
      say1_r <= side.say;
      dax1_r <= side.dax;
      day1_r <= side.day;
    end
  end

  // direction times parameter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prx_r  <= PRD_W'(dax1_r) * PRD_W'(t1_r);
      pry_r  <= PRD_W'(day1_r) * PRD_W'(t1_r);
      oc2_r  <= oc1_r;
      sax2_r <= sax1_r;
      say2_r <= say1_r;
    end
  end

  // floor shift, add start point, saturate
  always_comb begin
    sumx = SUM_W'(sax2_r) + SUM_W'(prx_r >>> FRAC_BITS);
    sumy = SUM_W'(say2_r) + SUM_W'(pry_r >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oc_r <= oc2_r;
      if (oc2_r != OC_HIT) begin
        px_r <= '0;
        py_r <= '0;
      end else begin
        px_r <= (sumx > SAT_HI) ? COORD_W'(SAT_HI) :
                (sumx < SAT_LO) ? COORD_W'(SAT_LO) : COORD_W'(sumx);
        py_r <= (sumy > SAT_HI) ? COORD_W'(SAT_HI) :
                (sumy < SAT_LO) ? COORD_W'(SAT_LO) : COORD_W'(sumy);
      end
    end
  end

  assign out_vld = out_vld_r;
  assign hit     = (oc_r == OC_HIT);
  assign outcome = oc_r;
  assign point_x = px_r;
  assign point_y = py_r;

endmodule

/* rtl/core/segment_intersection_2d.sv */
// ----------------------------------------------------------------------------
// segment_intersection_2d
// Intersection of two 2D segments given as start point and direction in
// signed Q16.16, with tolerance on the segment parameters.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* beat: one segment pair, eight 32-bit fields in in_tdata.
//  - out_* beat: hit flag and outcome code in out_tuser, point in out_tdata.
//    A miss gives a zero point; outcome tells parallel from outside.
//  - cfg_wr_en/cfg_wr_data write the 16-bit tolerance (reset value 7); write
//    it only while no pair is in flight.
//  - From input beat to result beat a pair passes the cross products, the
//    two pipelined dividers (one quotient bit per stage), then range check,
//    point multiply and the result register.
//  - Throughput is one pair per cycle when not stalled; all stages registered.
//  - The whole pipeline moves on one enable: it advances when the result
//    register is empty or taken. While out_tready is low with a result
//    held, in_tready drops and nothing is lost or repeated.
//  - rst_n (synchronous) clears all valid bits and reloads the tolerance.
// ----------------------------------------------------------------------------
module segment_intersection_2d import segi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // fields from bit 0: start_a_x, start_a_y, dir_a_x, dir_a_y,
  // start_b_x, start_b_y, dir_b_x, dir_b_y
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [8*COORD_W-1:0] in_tdata,
  // fields from bit 0: point_x, point_y
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [2*COORD_W-1:0] out_tdata,
  // fields from bit 0: hit, outcome
  output logic [2:0]         out_tuser,
  input  logic               cfg_wr_en,
  input  logic [TOL_W-1:0]   cfg_wr_data
);

  logic                   en;
  logic [TOL_W-1:0]       tol_r;
  logic                   vld_r  [PIPE_LAT];
  seg_side_t              side_r [DIV_LAT];

  logic signed [DEN_W-1:0] den;
  logic signed [NUM_W-1:0] num1, num2;
  seg_side_t               side;
  logic [QW-1:0]           q1, q2;
  logic                    neg1, neg2, ovf1, ovf2;

  logic                    res_vld, res_hit;
  logic [1:0]              res_oc;
  logic signed [COORD_W-1:0] res_px, res_py;

  // pipeline enable
  assign en        = out_tready | ~res_vld;
  assign in_tready = en;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(7);
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // valid bits beside front end and dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < PIPE_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // side data delayed across the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side;
      for (int i = 1; i < DIV_LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  segi_front u_front (
    .clk  (clk),
    .en   (en),
    .sax  (in_tdata[0*COORD_W +: COORD_W]),
    .say  (in_tdata[1*COORD_W +: COORD_W]),
    .dax  (in_tdata[2*COORD_W +: COORD_W]),
    .day  (in_tdata[3*COORD_W +: COORD_W]),
    .sbx  (in_tdata[4*COORD_W +: COORD_W]),
    .sby  (in_tdata[5*COORD_W +: COORD_W]),
    .dbx  (in_tdata[6*COORD_W +: COORD_W]),
    .dby  (in_tdata[7*COORD_W +: COORD_W]),
    .den  (den),
    .num1 (num1),
    .num2 (num2),
    .side (side)
  );

  segi_div u_div_t1 (
    .clk (clk),
    .en  (en),
    .num (num1),
    .den (den),
    .quo (q1),
    .neg (neg1),
    .ovf (ovf1)
  );

  segi_div u_div_t2 (
    .clk (clk),
    .en  (en),
    .num (num2),
    .den (den),
    .quo (q2),
    .neg (neg2),
    .ovf (ovf2)
  );

  segi_point u_point (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld_r[PIPE_LAT-1]),
    .q1      (q1),
    .neg1    (neg1),
    .ovf1    (ovf1),
    .q2      (q2),
    .neg2    (neg2),
    .ovf2    (ovf2),
    .side    (side_r[DIV_LAT-1]),
    .tol     (tol_r),
    .out_vld (res_vld),
    .hit     (res_hit),
    .outcome (res_oc),
    .point_x (res_px),
    .point_y (res_py)
  );

  assign out_tvalid = res_vld;
  assign out_tdata  = {res_py, res_px};
  assign out_tuser  = {res_oc, res_hit};

endmodule
